// File: rtl/teq_pkg.sv
// Package: shared types, codes and constants of the tap event qualifier.
package teq_pkg;

    // Window length in samples and the width of the sample counter.
    localparam int WINDOW_SAMPLES = 32;
    localparam int CNT_W          = $clog2(WINDOW_SAMPLES + 1);

    // Field widths.
    localparam int SUM_W   = 13;
    localparam int DELAY_W = 8;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 13;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Saturation limit of a window sum.
    localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

    // Interrupt source bits.
    localparam int SRC_PULSE_BIT       = 3;
    localparam int SRC_ORIENTATION_BIT = 4;
    localparam int SRC_TRANSIENT_BIT   = 5;

    // Pulse flag patterns for recognised taps.
    localparam logic [BYTE_W-1:0] PULSE_DOUBLE = 8'hCC;
    localparam logic [BYTE_W-1:0] PULSE_SINGLE = 8'hC4;

    // Fixed cross-axis limits.
    localparam logic [SUM_W-1:0] Z_CROSS_LIMIT  = 13'd110;
    localparam logic [SUM_W-1:0] XY_CROSS_LIMIT = 13'd70;

    // Configuration reset values.
    localparam logic [SUM_W-1:0]   Z_SUM_MAX_RST    = 13'd120;
    localparam logic [SUM_W-1:0]   Z_SUM_MIN_RST    = 13'd60;
    localparam logic [DELAY_W-1:0] REPORT_DELAY_RST = 8'd40;

    typedef enum logic [1:0] {
        OP_INTERRUPT = 2'd0,
        OP_SAMPLE    = 2'd1,
        OP_TICK      = 2'd2,
        OP_UNUSED    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_SINGLE       = 3'd1,
        EV_DOUBLE       = 3'd2,
        EV_SUPPRESSED   = 3'd3,
        EV_UNRECOGNISED = 3'd4
    } t_tap_event;

    typedef enum logic [IDX_W-1:0] {
        CFG_Z_SUM_MAX    = 2'd0,
        CFG_Z_SUM_MIN    = 2'd1,
        CFG_REPORT_DELAY = 2'd2,
        CFG_NONE         = 2'd3
    } t_cfg_index;

endpackage

// File: rtl/tap_event_qualifier_core.sv
// Top level: tap event qualifier with input register, single-pass logic and result register.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser opcode, tdata int_source..accel_z, tlast last_sample
//  m_axis    out        tuser window_checked, tdata tap_event..total_z
//  i_cfg_*   in         register index and write data, one write per cycle
//
// One item per cycle is sustained while the result side does not stall; a transfer in
// passes through the input register and then the result register.
// The state update and the window sums are done in the logic between them.
// Reset is synchronous; it clears the valid bits and the state and loads the configuration reset values.
// A stalled result holds the output register; the input register still takes
// a transfer while it is empty, then the input side stalls too.
module tap_event_qualifier_core
    import teq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: int_source[7:0], event_source[15:8], accel_x[23:16],
    //        accel_y[31:24], accel_z[39:32]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: tap_event[2:0], window_discarded[3], total_x[16:4],
    //        total_y[29:17], total_z[42:30], zero[47:43]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: window_checked[0]
    output logic                  m_axis_tuser
);

    // Configuration registers
    logic [SUM_W-1:0]   r_z_sum_max;
    logic [SUM_W-1:0]   r_z_sum_min;
    logic [DELAY_W-1:0] r_report_delay;

    // Input register
    logic               r_in_valid;
    t_opcode            r_opcode;
    logic [BYTE_W-1:0]  r_int_source;
    logic [BYTE_W-1:0]  r_event_source;
    logic [BYTE_W-1:0]  r_accel_x;
    logic [BYTE_W-1:0]  r_accel_y;
    logic [BYTE_W-1:0]  r_accel_z;
    logic               r_last_sample;

    // Qualifier state
    logic [BYTE_W-1:0]  r_pulse_flags,      n_pulse_flags;
    logic               r_transient_seen,   n_transient_seen;
    logic               r_orientation_seen, n_orientation_seen;
    logic               r_window_rejected,  n_window_rejected;
    logic [SUM_W-1:0]   r_acc_x,            n_acc_x;
    logic [SUM_W-1:0]   r_acc_y,            n_acc_y;
    logic [SUM_W-1:0]   r_acc_z,            n_acc_z;
    logic [DELAY_W-1:0] r_countdown,        n_countdown;
    logic               r_timer_armed,      n_timer_armed;
    logic [CNT_W-1:0]   r_sample_count,     n_sample_count;

    // Result register
    logic               r_out_valid;
    t_tap_event         r_tap_event,        n_tap_event;
    logic               r_window_checked,   n_window_checked;
    logic               r_window_discarded, n_window_discarded;
    logic [SUM_W-1:0]   r_total_x,          n_total_x;
    logic [SUM_W-1:0]   r_total_y,          n_total_y;
    logic [SUM_W-1:0]   r_total_z,          n_total_z;

    logic               out_load;
    logic               in_take;
    logic [SUM_W-1:0]   sum_x, sum_y, sum_z;
    logic [CNT_W-1:0]   count_inc;
    logic               window_close;
    logic               bad_window;
    logic               expire;

    // Handshake: the result register loads a held input item when it is empty or being drained
    assign out_load      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Absolute value of an 8-bit two's complement sample, 128 for -128.
    function automatic logic [BYTE_W-1:0] abs8(input logic [BYTE_W-1:0] v);
        abs8 = v[BYTE_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Saturating accumulate of one axis.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W+1-BYTE_W){1'b0}}, b};
        sat_add = s[SUM_W] ? SUM_SAT : s[SUM_W-1:0];
    endfunction

    // Window sums, close condition and rule check
    always_comb begin
        sum_x        = sat_add(r_acc_x, abs8(r_accel_x));
        sum_y        = sat_add(r_acc_y, abs8(r_accel_y));
        sum_z        = sat_add(r_acc_z, abs8(r_accel_z));
        count_inc    = r_sample_count + 1'b1;
        window_close = r_last_sample || (count_inc >= CNT_W'(WINDOW_SAMPLES));
        bad_window   = (sum_x > sum_z) || (sum_y > sum_z) ||
                       (sum_z > r_z_sum_max) || (sum_z < r_z_sum_min) ||
                       ((sum_z > Z_CROSS_LIMIT) &&
                        ((sum_x > XY_CROSS_LIMIT) || (sum_y > XY_CROSS_LIMIT)));
        expire       = r_timer_armed && (r_countdown <= DELAY_W'(1));
    end

    // Next state and result for the item in the input register
    always_comb begin
        n_pulse_flags      = r_pulse_flags;
        n_transient_seen   = r_transient_seen;
        n_orientation_seen = r_orientation_seen;
        n_window_rejected  = r_window_rejected;
        n_acc_x            = r_acc_x;
        n_acc_y            = r_acc_y;
        n_acc_z            = r_acc_z;
        n_countdown        = r_countdown;
        n_timer_armed      = r_timer_armed;
        n_sample_count     = r_sample_count;
        n_tap_event        = EV_NONE;
        n_window_checked   = 1'b0;
        n_window_discarded = 1'b0;
        n_total_x          = '0;
        n_total_y          = '0;
        n_total_z          = '0;
        case (r_opcode)
            OP_INTERRUPT: begin
                // Only the highest-priority source is handled; each one rearms
                if (r_int_source[SRC_PULSE_BIT]) begin
                    n_pulse_flags = r_pulse_flags | r_event_source;
                    n_countdown   = r_report_delay;
                    n_timer_armed = 1'b1;
                end else if (r_int_source[SRC_TRANSIENT_BIT]) begin
                    n_transient_seen = 1'b1;
                    n_countdown      = r_report_delay;
                    n_timer_armed    = 1'b1;
                end else if (r_int_source[SRC_ORIENTATION_BIT]) begin
                    n_orientation_seen = 1'b1;
                    n_countdown        = r_report_delay;
                    n_timer_armed      = 1'b1;
                end
            end
            OP_SAMPLE: begin
                if (window_close) begin
                    n_window_rejected  = r_window_rejected || bad_window;
                    n_window_checked   = 1'b1;
                    n_window_discarded = bad_window;
                    n_total_x          = sum_x;
                    n_total_y          = sum_y;
                    n_total_z          = sum_z;
                    n_acc_x            = '0;
                    n_acc_y            = '0;
                    n_acc_z            = '0;
                    n_sample_count     = '0;
                end else begin
                    n_acc_x        = sum_x;
                    n_acc_y        = sum_y;
                    n_acc_z        = sum_z;
                    n_sample_count = count_inc;
                end
            end
            OP_TICK: begin
                if (expire) begin
                    if (r_transient_seen || r_orientation_seen || r_window_rejected) begin
                        n_tap_event = EV_SUPPRESSED;
                    end else if (r_pulse_flags == PULSE_DOUBLE) begin
                        n_tap_event = EV_DOUBLE;
                    end else if (r_pulse_flags == PULSE_SINGLE) begin
                        n_tap_event = EV_SINGLE;
                    end else begin
                        n_tap_event = EV_UNRECOGNISED;
                    end
                    n_pulse_flags      = '0;
                    n_transient_seen   = 1'b0;
                    n_orientation_seen = 1'b0;
                    n_window_rejected  = 1'b0;
                    n_timer_armed      = 1'b0;
                    n_countdown        = '0;
                end else if (r_timer_armed) begin
                    n_countdown = r_countdown - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_sum_max    <= Z_SUM_MAX_RST;
            r_z_sum_min    <= Z_SUM_MIN_RST;
            r_report_delay <= REPORT_DELAY_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_Z_SUM_MAX:    r_z_sum_max    <= i_cfg_data[SUM_W-1:0];
                CFG_Z_SUM_MIN:    r_z_sum_min    <= i_cfg_data[SUM_W-1:0];
                CFG_REPORT_DELAY: r_report_delay <= i_cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode       <= t_opcode'(s_axis_tuser);
            r_int_source   <= s_axis_tdata[7:0];
            r_event_source <= s_axis_tdata[15:8];
            r_accel_x      <= s_axis_tdata[23:16];
            r_accel_y      <= s_axis_tdata[31:24];
            r_accel_z      <= s_axis_tdata[39:32];
            r_last_sample  <= s_axis_tlast;
        end
    end

    // Qualifier state, updated as each item passes into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_flags      <= '0;
            r_transient_seen   <= 1'b0;
            r_orientation_seen <= 1'b0;
            r_window_rejected  <= 1'b0;
            r_acc_x            <= '0;
            r_acc_y            <= '0;
            r_acc_z            <= '0;
            r_countdown        <= '0;
            r_timer_armed      <= 1'b0;
            r_sample_count     <= '0;
        end else if (out_load) begin
            r_pulse_flags      <= n_pulse_flags;
            r_transient_seen   <= n_transient_seen;
            r_orientation_seen <= n_orientation_seen;
            r_window_rejected  <= n_window_rejected;
            r_acc_x            <= n_acc_x;
            r_acc_y            <= n_acc_y;
            r_acc_z            <= n_acc_z;
            r_countdown        <= n_countdown;
            r_timer_armed      <= n_timer_armed;
            r_sample_count     <= n_sample_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_tap_event        <= n_tap_event;
            r_window_checked   <= n_window_checked;
            r_window_discarded <= n_window_discarded;
            r_total_x          <= n_total_x;
            r_total_y          <= n_total_y;
            r_total_z          <= n_total_z;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_window_checked;
    assign m_axis_tdata  = {{(M_TDATA_W - 3 - 1 - 3*SUM_W){1'b0}},
                            r_total_z, r_total_y, r_total_x,
                            r_window_discarded, r_tap_event};

    // A result that closes no window carries no verdict and no totals.
    a_unchecked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_window_checked) |->
            (!r_window_discarded && r_total_x == '0 && r_total_y == '0 && r_total_z == '0))
        else $error("window fields set on a result that closed no window");

    // A tap decision and a window close never come from the same item.
    a_event_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tap_event != EV_NONE) |-> !r_window_checked)
        else $error("tap decision and window close on one result");

    // The countdown is zero whenever the timer is not armed.
    a_idle_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timer_armed |-> (r_countdown == '0))
        else $error("countdown running while timer not armed");

    // After a decision every flag is clear and the timer is disarmed.
    a_expiry_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_tap_event != EV_NONE) |=>
            (r_pulse_flags == '0 && !r_transient_seen && !r_orientation_seen &&
             !r_window_rejected && !r_timer_armed))
        else $error("flags not cleared after a tap decision");

endmodule

// File: tb/sv/testbench.sv
// Self-checking stream testbench for the tap event qualifier core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_PCT    = 19;

    // One input item as the block sees it, and the result it should produce.
    typedef struct {
        t_opcode                  op;
        logic [BYTE_W-1:0]        int_src;
        logic [BYTE_W-1:0]        evt_src;
        logic signed [BYTE_W-1:0] ax;
        logic signed [BYTE_W-1:0] ay;
        logic signed [BYTE_W-1:0] az;
        logic                     last;
    } t_tap_item;

    typedef struct {
        t_tap_event       ev;
        logic             checked;
        logic             discarded;
        logic [SUM_W-1:0] tx;
        logic [SUM_W-1:0] ty;
        logic [SUM_W-1:0] tz;
    } t_tap_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // Predicted configuration and state of the qualifier.
    logic [SUM_W-1:0]   cfg_zmax  = Z_SUM_MAX_RST;
    logic [SUM_W-1:0]   cfg_zmin  = Z_SUM_MIN_RST;
    logic [DELAY_W-1:0] cfg_delay = REPORT_DELAY_RST;
    logic [BYTE_W-1:0]  pflags      = '0;
    logic               trans_flag  = 1'b0;
    logic               orient_flag = 1'b0;
    logic               veto_flag   = 1'b0;
    logic               armed       = 1'b0;
    logic [DELAY_W-1:0] countdown   = '0;
    logic [SUM_W-1:0]   sum_x = '0;
    logic [SUM_W-1:0]   sum_y = '0;
    logic [SUM_W-1:0]   sum_z = '0;
    int                 win_len = 0;

    t_tap_result expected_results[$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          stall_cycles = 0;
    logic        src_busy     = 1'b0;
    logic        src_idle_en  = 1'b1;
    logic        sink_idle_en = 1'b1;
    logic        hold_sink    = 1'b0;

    tap_event_qualifier_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Absolute value of a signed byte; the most negative value gives 128.
    function automatic int mag8(logic signed [BYTE_W-1:0] v);
        int a;
        a = v;
        return (a < 0) ? -a : a;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, int mag);
        int s;
        s = int'(acc) + mag;
        return (s > int'(SUM_SAT)) ? SUM_SAT : s[SUM_W-1:0];
    endfunction

    // Advances the predicted state by one item and returns the result it causes.
    function automatic t_tap_result qualify_item(t_tap_item it);
        t_tap_result r;
        logic        rearm;
        logic        bad;
        r.ev        = EV_NONE;
        r.checked   = 1'b0;
        r.discarded = 1'b0;
        r.tx        = '0;
        r.ty        = '0;
        r.tz        = '0;
        rearm       = 1'b0;
        case (it.op)
            OP_INTERRUPT: begin
                // Only the highest-priority source bit is handled.
                if (it.int_src[SRC_PULSE_BIT]) begin
                    pflags |= it.evt_src;
                    rearm = 1'b1;
                end else if (it.int_src[SRC_TRANSIENT_BIT]) begin
                    trans_flag = 1'b1;
                    rearm = 1'b1;
                end else if (it.int_src[SRC_ORIENTATION_BIT]) begin
                    orient_flag = 1'b1;
                    rearm = 1'b1;
                end
                if (rearm) begin
                    countdown = cfg_delay;
                    armed = 1'b1;
                end
            end
            OP_SAMPLE: begin
                sum_x = sat_sum(sum_x, mag8(it.ax));
                sum_y = sat_sum(sum_y, mag8(it.ay));
                sum_z = sat_sum(sum_z, mag8(it.az));
                win_len++;
                if (it.last || win_len >= WINDOW_SAMPLES) begin
                    bad = (sum_x > sum_z) || (sum_y > sum_z) ||
                          (sum_z > cfg_zmax) || (sum_z < cfg_zmin) ||
                          ((sum_z > Z_CROSS_LIMIT) &&
                           ((sum_x > XY_CROSS_LIMIT) || (sum_y > XY_CROSS_LIMIT)));
                    if (bad)
                        veto_flag = 1'b1;
                    r.checked   = 1'b1;
                    r.discarded = bad;
                    r.tx        = sum_x;
                    r.ty        = sum_y;
                    r.tz        = sum_z;
                    sum_x       = '0;
                    sum_y       = '0;
                    sum_z       = '0;
                    win_len     = 0;
                end
            end
            OP_TICK: begin
                if (armed) begin
                    if (countdown <= 1) begin
                        if (trans_flag || orient_flag || veto_flag)
                            r.ev = EV_SUPPRESSED;
                        else if (pflags == PULSE_DOUBLE)
                            r.ev = EV_DOUBLE;
                        else if (pflags == PULSE_SINGLE)
                            r.ev = EV_SINGLE;
                        else
                            r.ev = EV_UNRECOGNISED;
                        pflags      = '0;
                        trans_flag  = 1'b0;
                        orient_flag = 1'b0;
                        veto_flag   = 1'b0;
                        armed       = 1'b0;
                        countdown   = '0;
                    end else begin
                        countdown--;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Checks each result transfer against the oldest prediction, then predicts
    // the result of each input transfer.
    always @(posedge i_clk) begin : monitor
        t_tap_item   it;
        t_tap_result exp_r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer arrived with no result expected");
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("tap_event", exp_r.ev, m_axis_tdata[2:0]);
                    check_field("window_checked", exp_r.checked, m_axis_tuser);
                    check_field("window_discarded", exp_r.discarded, m_axis_tdata[3]);
                    check_field("total_x", exp_r.tx, m_axis_tdata[16:4]);
                    check_field("total_y", exp_r.ty, m_axis_tdata[29:17]);
                    check_field("total_z", exp_r.tz, m_axis_tdata[42:30]);
                    check_field("tdata_pad", 0, m_axis_tdata[47:43]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it.op      = t_opcode'(s_axis_tuser);
                it.int_src = s_axis_tdata[7:0];
                it.evt_src = s_axis_tdata[15:8];
                it.ax      = s_axis_tdata[23:16];
                it.ay      = s_axis_tdata[31:24];
                it.az      = s_axis_tdata[39:32];
                it.last    = s_axis_tlast;
                expected_results.push_back(qualify_item(it));
            end
        end
    end

    // Watchdog: ends the run when no input transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result receiver: random stalls, or a long hold-off on request.
    always begin : sink
        @(posedge i_clk);
        if (hold_sink) begin
            m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_sink = 1'b0;
        end else begin
            m_axis_tready <= !sink_idle_en || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(t_tap_item it);
        if (src_idle_en) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                if (src_busy) begin
                    s_axis_tvalid <= 1'b0;
                    src_busy = 1'b0;
                end
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {it.az, it.ay, it.ax, it.evt_src, it.int_src};
        s_axis_tlast  <= it.last;
        src_busy = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has arrived.
    task automatic wait_results_drained();
        if (src_busy) begin
            s_axis_tvalid <= 1'b0;
            src_busy = 1'b0;
        end
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes all three registers and one unused index; the block must be idle.
    task automatic write_config(int zmax, int zmin, int delay);
        logic [CFG_W-1:0] delay_word;
        delay_word = CFG_W'(delay);
        delay_word[CFG_W-1:DELAY_W] = (CFG_W-DELAY_W)'($urandom);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_Z_SUM_MAX;
        i_cfg_data  <= CFG_W'(zmax);
        @(posedge i_clk);
        i_cfg_index <= CFG_Z_SUM_MIN;
        i_cfg_data  <= CFG_W'(zmin);
        @(posedge i_clk);
        i_cfg_index <= CFG_REPORT_DELAY;
        i_cfg_data  <= delay_word;
        @(posedge i_clk);
        i_cfg_index <= CFG_NONE;
        i_cfg_data  <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_zmax  = CFG_W'(zmax);
        cfg_zmin  = CFG_W'(zmin);
        cfg_delay = delay_word[DELAY_W-1:0];
    endtask

    function automatic t_tap_item make_item(t_opcode op, int src, int evt,
                                            int x, int y, int z, bit last);
        t_tap_item it;
        it.op      = op;
        it.int_src = BYTE_W'(src);
        it.evt_src = BYTE_W'(evt);
        it.ax      = BYTE_W'(x);
        it.ay      = BYTE_W'(y);
        it.az      = BYTE_W'(z);
        it.last    = last;
        return it;
    endfunction

    function automatic t_tap_item random_item();
        t_tap_item it;
        it.op      = t_opcode'($urandom_range(3));
        it.int_src = BYTE_W'($urandom);
        it.evt_src = BYTE_W'($urandom);
        it.ax      = BYTE_W'($urandom);
        it.ay      = BYTE_W'($urandom);
        it.az      = BYTE_W'($urandom);
        it.last    = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic logic signed [BYTE_W-1:0] signed_of(int mag);
        if (mag >= 128)
            return -8'sd128;
        return ($urandom_range(1) != 0) ? BYTE_W'(-mag) : BYTE_W'(mag);
    endfunction

    task automatic send_ticks(int n);
        repeat (n) send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    endtask

    // A well-formed gesture: interrupts, sample windows shaped to the current
    // bounds, then enough ticks to reach the decision.
    task automatic send_gesture();
        t_tap_item it;
        int        len;
        int        zlo;
        int        zhi;
        int        zmag;
        int        xymax;
        repeat ($urandom_range(1, 3)) begin
            it = random_item();
            it.op = OP_INTERRUPT;
            case ($urandom_range(9))
                0: it.int_src = (it.int_src & 8'hD7) | 8'h20;
                1: it.int_src = (it.int_src & 8'hC7) | 8'h10;
                default: begin
                    it.int_src = it.int_src | 8'h08;
                    case ($urandom_range(4))
                        0: it.evt_src = PULSE_SINGLE;
                        1: it.evt_src = PULSE_DOUBLE;
                        2: it.evt_src = 8'h08;
                        3: it.evt_src = 8'h44;
                        default: begin
                        end
                    endcase
                end
            endcase
            send_item(it);
        end
        repeat ($urandom_range(0, 2)) begin
            len = ($urandom_range(15) == 0) ? WINDOW_SAMPLES : $urandom_range(1, 6);
            zhi = int'(cfg_zmax) / len;
            if (zhi > 128)
                zhi = 128;
            zlo = (int'(cfg_zmin) + len - 1) / len;
            for (int i = 0; i < len; i++) begin
                it = random_item();
                it.op = OP_SAMPLE;
                if (zlo <= zhi && $urandom_range(4) != 0) begin
                    zmag  = $urandom_range(zlo, zhi);
                    xymax = 70 / len;
                    if (xymax > zmag)
                        xymax = zmag;
                    it.az = signed_of(zmag);
                    it.ax = signed_of($urandom_range(0, xymax));
                    it.ay = signed_of($urandom_range(0, xymax));
                end
                it.last = (i == len - 1) ? ((len < WINDOW_SAMPLES) || it.last) : 1'b0;
                send_item(it);
            end
        end
        // Ticks up to the decision, with the odd sample in between.
        for (int t = 0; t < ((cfg_delay == 0) ? 1 : int'(cfg_delay)); t++) begin
            if ($urandom_range(19) == 0) begin
                it = random_item();
                it.op = OP_SAMPLE;
                send_item(it);
            end
            send_ticks(1);
        end
        if ($urandom_range(4) == 0)
            send_ticks(1);
    endtask

    // Reset values of the registers: a good window and a double tap after
    // the full default delay.
    task automatic test_reset_values();
        send_item(make_item(OP_SAMPLE, 0, 0, 5, -5, 40, 0));
        send_item(make_item(OP_SAMPLE, 0, 0, -5, 5, -40, 1));
        send_item(make_item(OP_INTERRUPT, 8'h08, PULSE_SINGLE, 0, 0, 0, 0));
        send_item(make_item(OP_INTERRUPT, 8'h08, 8'h08, 0, 0, 0, 0));
        send_ticks(int'(REPORT_DELAY_RST));
        wait_results_drained();
    endtask

    // Every opcode, interrupt priority and each kind of decision.
    task automatic test_directed();
        write_config(120, 60, 1);
        send_item(make_item(OP_UNUSED, 8'hFF, 8'hFF, -1, -1, -1, 1));
        send_item(make_item(OP_INTERRUPT, 8'h40, 8'hFF, 0, 0, 0, 0));
        send_item(make_item(OP_INTERRUPT, 8'h00, 8'hFF, 0, 0, 0, 0));
        send_ticks(1);
        send_item(make_item(OP_INTERRUPT, 8'hFF, PULSE_DOUBLE, 0, 0, 0, 0));
        send_ticks(1);
        send_item(make_item(OP_INTERRUPT, 8'h88, PULSE_SINGLE, 0, 0, 0, 0));
        send_ticks(1);
        send_item(make_item(OP_INTERRUPT, 8'h08, 8'h01, 0, 0, 0, 0));
        send_ticks(1);
        send_item(make_item(OP_INTERRUPT, 8'h38, 8'h00, 0, 0, 0, 0));
        send_ticks(1);
        send_item(make_item(OP_INTERRUPT, 8'h10, 8'h00, 0, 0, 0, 0));
        send_ticks(1);
        // A rejected window vetoes the next tap.
        send_item(make_item(OP_SAMPLE, 0, 0, -128, 127, -128, 1));
        send_item(make_item(OP_INTERRUPT, 8'h08, PULSE_DOUBLE, 0, 0, 0, 0));
        send_ticks(1);
        send_item(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 1));
        send_item(make_item(OP_SAMPLE, 0, 0, -10, 20, -70, 1));
        send_ticks(1);
        wait_results_drained();
    endtask

    // Zero delay expires on the first tick; the largest delay needs 255.
    task automatic test_delay_extremes();
        write_config(120, 60, 0);
        send_item(make_item(OP_INTERRUPT, 8'h08, PULSE_SINGLE, 0, 0, 0, 0));
        send_ticks(1);
        wait_results_drained();
        write_config(4096, 0, 255);
        send_item(make_item(OP_INTERRUPT, 8'h08, PULSE_DOUBLE, 0, 0, 0, 0));
        send_ticks(100);
        // A new interrupt restarts the countdown.
        send_item(make_item(OP_INTERRUPT, 8'h08, PULSE_DOUBLE, 0, 0, 0, 0));
        send_ticks(256);
        wait_results_drained();
    endtask

    // Windows closed by the sample count, one at the largest sums, then a short window closed by its last sample.
    task automatic test_full_windows();
        t_tap_item it;
        write_config(8191, 0, 1);
        repeat (WINDOW_SAMPLES) send_item(make_item(OP_SAMPLE, 0, 0, -128, -128, -128, 0));
        for (int i = 0; i < WINDOW_SAMPLES; i++) begin
            it = random_item();
            it.op = OP_SAMPLE;
            it.last = (i == WINDOW_SAMPLES - 1);
            send_item(it);
        end
        repeat (3) send_item(make_item(OP_SAMPLE, 0, 0, 3, -3, 50, 0));
        send_item(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 1));
        wait_results_drained();
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        write_config(120, 60, 2);
        hold_sink = 1'b1;
        repeat (20) send_item(random_item());
        wait_results_drained();
    endtask

    task automatic test_random_phase(int n_items, int zmax, int zmin, int delay, bit no_idle);
        int stop_at;
        write_config(zmax, zmin, delay);
        src_idle_en  = !no_idle;
        sink_idle_en = !no_idle;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 25)
                send_item(random_item());
            else
                send_gesture();
        end
        wait_results_drained();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_NONE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_UNUSED;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed();
        test_delay_extremes();
        test_full_windows();
        test_backpressure();
        test_random_phase(400, 120, 60, 3, 0);
        test_random_phase(300, 4096, 0, 1, 1);
        test_random_phase(200, 0, 4096, 6, 0);
        test_random_phase(300, 300, 100, 255, 0);
        test_random_phase(200, 120, 60, 0, 0);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/teq_pkg.sv
rtl/tap_event_qualifier_core.sv
tb/sv/testbench.sv
